// ===== sv/sgcr_pkg.sv =====
// ---------------------------------------------------------------------------
// sgcr_pkg
// Shared types, constants and the 5x7 font ROM for the glyph cell renderer.
// ---------------------------------------------------------------------------
`default_nettype none

package sgcr_pkg;

  localparam int unsigned GLYPH_FIRST = 32;
  localparam int unsigned GLYPH_LAST  = 126;
  localparam int unsigned GLYPH_COUNT = GLYPH_LAST - GLYPH_FIRST + 1;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;

  localparam logic [3:0] SCALE_MIN = 4'd1;
  localparam logic [3:0] SCALE_MAX = 4'd8;

  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

  localparam logic REG_SCALE = 1'b0;

  typedef logic [6:0]  glyph_idx_t;
  typedef logic [10:0] addr_t;

  // Element 0 is column 0 (leftmost byte of each literal).
  typedef logic [0:4][7:0] glyph_t;

  localparam glyph_t FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
    40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e,
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
    40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
    40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
    40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
    40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081620, 40'h0041417f00, 40'h0402010204,
    40'h4040404040, 40'h0001020500, 40'h2054545478,
    40'h7f48444438, 40'h3844444420, 40'h384444487f,
    40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
    40'h7c08040478, 40'h3844444438, 40'h7c14141408,
    40'h081414147c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
    40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000,
    40'h0041360800, 40'h1008181008
  };

endpackage

`default_nettype wire

// ===== sv/scaled_glyph_cell_renderer_unit.sv =====
// ---------------------------------------------------------------------------
// scaled_glyph_cell_renderer_unit
// Renders one 5x7 character as 35 scaled, single-color panel windows.
// ---------------------------------------------------------------------------
// A character is taken when start_i is high and busy_o is low. The font ROM
// is read synchronously at that edge; the 35 cell beats then follow on
// cell_valid_o, column-major, one per cycle, with last_cell_o on the final
// one. The output has no back-pressure: every beat is present for exactly
// one cycle and must be taken. busy_o drops during the last beat, so
// characters can be issued back to back.
`default_nettype none

module scaled_glyph_cell_renderer_unit
  import sgcr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // character command
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [9:0]  origin_x_i,
  input  wire logic [9:0]  origin_y_i,
  input  wire logic [15:0] text_color_i,
  input  wire logic [15:0] back_color_i,
  // cell beats
  output logic             cell_valid_o,
  output logic [10:0]      column_first_o,
  output logic [10:0]      page_first_o,
  output logic [10:0]      column_last_o,
  output logic [10:0]      page_last_o,
  output logic [15:0]      cell_color_o,
  output logic [6:0]       pixel_repeat_o,
  output logic             last_cell_o
);

  logic [3:0] scale_val_q;
  logic [3:0] scale_d;
  logic       cfg_wr;

  logic       active_q;
  logic [2:0] col_q;
  logic [2:0] row_q;
  logic       last;
  logic       accept;

  glyph_idx_t glyph_idx;
  glyph_t     glyph_q;
  addr_t      cf_q;
  addr_t      pf_q;
  addr_t      oy_q;
  logic [15:0] fg_q;
  logic [15:0] bg_q;
  addr_t      step;
  logic [7:0] square;
  logic [7:0] col_byte;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCALE);

  always_comb begin
    scale_d = pwdata[3:0];
    if (scale_d < SCALE_MIN) begin
      scale_d = SCALE_MIN;
    end else if (scale_d > SCALE_MAX) begin
      scale_d = SCALE_MAX;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SCALE) begin
      prdata = {28'd0, scale_val_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_val_q <= SCALE_MIN;
    end else if (cfg_wr) begin
      scale_val_q <= scale_d;
    end
  end

  // sequencing
  assign last   = (col_q == LAST_COL) && (row_q == LAST_ROW);
  assign busy_o = active_q && !last;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (accept) begin
      active_q <= 1'b1;
      col_q    <= '0;
      row_q    <= '0;
    end else if (active_q) begin
      if (last) begin
        active_q <= 1'b0;
        col_q    <= '0;
        row_q    <= '0;
      end else if (row_q == LAST_ROW) begin
        row_q <= '0;
        col_q <= col_q + 3'd1;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  // font ROM read and running window addresses
  always_comb begin
    if ((char_code_i >= 8'(GLYPH_FIRST)) && (char_code_i <= 8'(GLYPH_LAST))) begin
      glyph_idx = 7'(char_code_i - 8'(GLYPH_FIRST));
    end else begin
      glyph_idx = '0;
    end
  end

  assign step = {7'd0, scale_val_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      glyph_q <= FONT_ROM[glyph_idx];
      cf_q    <= {1'b0, origin_y_i};
      pf_q    <= {1'b0, origin_x_i};
      oy_q    <= {1'b0, origin_y_i};
      fg_q    <= text_color_i;
      bg_q    <= back_color_i;
    end else if (active_q && !last) begin
      if (row_q == LAST_ROW) begin
        cf_q <= oy_q;
        pf_q <= pf_q + step;
      end else begin
        cf_q <= cf_q + step;
      end
    end
  end

  // beat outputs
  assign square   = {4'd0, scale_val_q} * {4'd0, scale_val_q};
  assign col_byte = glyph_q[col_q];

  assign cell_valid_o   = active_q;
  assign column_first_o = cf_q;
  assign page_first_o   = pf_q;
  assign column_last_o  = cf_q + step - 11'd1;
  assign page_last_o    = pf_q + step - 11'd1;
  assign cell_color_o   = col_byte[row_q] ? fg_q : bg_q;
  assign pixel_repeat_o = square[6:0];
  assign last_cell_o    = last;

endmodule

`default_nettype wire
